[rtl/core/mscell_pkg.sv]
`timescale 1ns / 1ps

package mscell_pkg;

  localparam int unsigned COORD_W  = 18;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 10;

  // configuration register indexes
  localparam logic CFG_ISO_LEVEL    = 1'b0;
  localparam logic CFG_DECIDER_MODE = 1'b1;

  // cell edges
  typedef enum logic [1:0] {
    EDGE_BOTTOM,
    EDGE_UP,
    EDGE_LEFT,
    EDGE_RIGHT
  } edge_e;

  typedef struct packed {
    logic        [INDEX_W-1:0]  cell_col;
    logic        [INDEX_W-1:0]  cell_row;
    logic signed [SAMPLE_W-1:0] corner_ll;
    logic signed [SAMPLE_W-1:0] corner_ul;
    logic signed [SAMPLE_W-1:0] corner_lr;
    logic signed [SAMPLE_W-1:0] corner_ur;
  } cell_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               last_segment;
  } seg_out_t;

  // classified cell, front to back
  typedef struct packed {
    logic        [INDEX_W-1:0]       col;
    logic        [INDEX_W-1:0]       row;
    logic signed [SAMPLE_W-1:0]      ll;
    logic signed [SAMPLE_W-1:0]      ul;
    logic signed [SAMPLE_W-1:0]      lr;
    logic signed [SAMPLE_W-1:0]      ur;
    logic signed [SAMPLE_W-1:0]      iso;
    logic                            mode;
    logic                            up0;
    logic                            saddle;
    edge_e                           e0;
    edge_e                           e1;
    logic [3:0][SAMPLE_W-1:0]        un;
    logic [3:0][SAMPLE_W-1:0]        ud;
  } cell_item_t;

  // side data carried along the back pipeline
  typedef struct packed {
    logic        [INDEX_W-1:0]  col;
    logic        [INDEX_W-1:0]  row;
    logic signed [SAMPLE_W-1:0] iso;
    logic                       mode;
    logic                       up0;
    logic                       saddle;
    edge_e                      e0;
    edge_e                      e1;
    logic signed [31:0]         p1;
    logic signed [31:0]         p2;
    logic signed [17:0]         den;
    logic signed [17:0]         sum;
    logic signed [32:0]         num;
    logic signed [33:0]         id;
    logic                       above;
  } cell_side_t;

endpackage

[rtl/core/mscell_fifo.sv]
`timescale 1ns / 1ps

module mscell_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [0:1];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];
  assign push    = valid_i & ready_o;
  assign pop     = valid_o & ready_i;

  // hold pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // store item
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

endmodule

[rtl/core/mscell_front.sv]
`timescale 1ns / 1ps

module mscell_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mscell_pkg::cell_in_t   in_data_i,
  input  logic signed [15:0]     iso_level_i,
  input  logic                   decider_mode_i,
  output logic                   item_valid_o,
  input  logic                   item_ready_i,
  output mscell_pkg::cell_item_t item_o
);

  function automatic logic [15:0] absdiff(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(b) - 17'(a);
    return d[16] ? 16'(-d) : 16'(d);
  endfunction

  logic                   fv_q;
  mscell_pkg::cell_item_t item_q, item_d;
  logic [3:0]             up;
  logic [2:0]             cnt;
  logic                   active, want;
  logic [1:0]             odd;
  logic signed [15:0]     v [0:3];

  assign v[0] = in_data_i.corner_ll;
  assign v[1] = in_data_i.corner_ul;
  assign v[2] = in_data_i.corner_lr;
  assign v[3] = in_data_i.corner_ur;

  // class corners and pick crossed edges
  always_comb begin
    for (int i = 0; i < 4; i++) up[i] = (v[i] >= iso_level_i);
    cnt    = {2'b0, up[0]} + {2'b0, up[1]} + {2'b0, up[2]} + {2'b0, up[3]};
    active = (cnt != 3'd0) && (cnt != 3'd4);
    want   = (cnt == 3'd1);
    odd    = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (up[i] == want) odd = 2'(i);
    end
    item_d        = '0;
    item_d.col    = in_data_i.cell_col;
    item_d.row    = in_data_i.cell_row;
    item_d.ll     = v[0];
    item_d.ul     = v[1];
    item_d.lr     = v[2];
    item_d.ur     = v[3];
    item_d.iso    = iso_level_i;
    item_d.mode   = decider_mode_i;
    item_d.up0    = up[0];
    item_d.saddle = 1'b0;
    item_d.e0     = mscell_pkg::EDGE_BOTTOM;
    item_d.e1     = mscell_pkg::EDGE_LEFT;
    if (cnt[0]) begin
      item_d.e0 = (odd == 2'd0 || odd == 2'd2) ? mscell_pkg::EDGE_BOTTOM : mscell_pkg::EDGE_UP;
      item_d.e1 = (odd == 2'd0 || odd == 2'd1) ? mscell_pkg::EDGE_LEFT : mscell_pkg::EDGE_RIGHT;
    end else if (up[0] == up[2]) begin
      item_d.e0 = mscell_pkg::EDGE_LEFT;
      item_d.e1 = mscell_pkg::EDGE_RIGHT;
    end else if (up[0] == up[1]) begin
      item_d.e0 = mscell_pkg::EDGE_UP;
      item_d.e1 = mscell_pkg::EDGE_BOTTOM;
    end else begin
      item_d.saddle = 1'b1;
    end
    // edge offsets: bottom ll-lr, up ul-ur, left ll-ul, right lr-ur
    item_d.un[mscell_pkg::EDGE_BOTTOM] = absdiff(v[0], iso_level_i);
    item_d.ud[mscell_pkg::EDGE_BOTTOM] = absdiff(v[0], v[2]);
    item_d.un[mscell_pkg::EDGE_UP]     = absdiff(v[1], iso_level_i);
    item_d.ud[mscell_pkg::EDGE_UP]     = absdiff(v[1], v[3]);
    item_d.un[mscell_pkg::EDGE_LEFT]   = absdiff(v[0], iso_level_i);
    item_d.ud[mscell_pkg::EDGE_LEFT]   = absdiff(v[0], v[1]);
    item_d.un[mscell_pkg::EDGE_RIGHT]  = absdiff(v[2], iso_level_i);
    item_d.ud[mscell_pkg::EDGE_RIGHT]  = absdiff(v[2], v[3]);
  end

  assign in_ready_o   = !fv_q || item_ready_i;
  assign item_valid_o = fv_q;
  assign item_o       = item_q;

  // hold the classified item; drop inactive cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_ready_o) begin
      fv_q <= in_valid_i && active;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= item_d;
  end

endmodule

[rtl/core/mscell_back.sv]
`timescale 1ns / 1ps

module mscell_back #(
  parameter int unsigned GRID_DIM  = 1024,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  mscell_pkg::cell_item_t item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output mscell_pkg::seg_out_t   out_data_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = 16 + FRAC_BITS + 1;
  localparam int unsigned CW = 12 + FRAC_BITS;
  localparam int unsigned CO = mscell_pkg::COORD_W;

  function automatic logic [CO-1:0] make_coord(logic [10:0] idx, logic [QW-1:0] frac);
    logic [CW-1:0] c, lim;
    lim = CW'(GRID_DIM - 1) << FRAC_BITS;
    c   = (CW'(idx) << FRAC_BITS) + CW'(frac);
    if (c > lim) c = lim;
    return CO'(c);
  endfunction

  logic                   en;
  logic                   sv_q   [0:QW];
  mscell_pkg::cell_side_t side_q [0:QW];
  logic [NW-1:0]          rem_q  [0:QW][0:3];
  logic [15:0]            ud_q   [0:QW][0:3];
  logic [QW-1:0]          quo_q  [0:QW][0:3];

  // output hold stage
  logic                   hv_q, hseg_q, two_q, last;
  mscell_pkg::edge_e      ord_q  [0:3];
  mscell_pkg::edge_e      ord_d  [0:3];
  logic [CO-1:0]          px_q   [0:3];
  logic [CO-1:0]          py_q   [0:3];
  logic [CO-1:0]          px_d   [0:3];
  logic [CO-1:0]          py_d   [0:3];
  logic [QW-1:0]          fr     [0:3];
  logic                   flip;

  assign last         = !two_q || hseg_q;
  assign en           = !hv_q || (out_ready_i && last);
  assign item_ready_o = en;

  // load pipeline head: dividends and products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= item_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].col    <= item_i.col;
      side_q[0].row    <= item_i.row;
      side_q[0].iso    <= item_i.iso;
      side_q[0].mode   <= item_i.mode;
      side_q[0].up0    <= item_i.up0;
      side_q[0].saddle <= item_i.saddle;
      side_q[0].e0     <= item_i.e0;
      side_q[0].e1     <= item_i.e1;
      side_q[0].p1     <= 32'(item_i.ll) * 32'(item_i.ur);
      side_q[0].p2     <= 32'(item_i.lr) * 32'(item_i.ul);
      side_q[0].den    <= 18'(item_i.ll) + 18'(item_i.ur) - 18'(item_i.lr) - 18'(item_i.ul);
      side_q[0].sum    <= 18'(item_i.ll) + 18'(item_i.ur) + 18'(item_i.lr) + 18'(item_i.ul);
      side_q[0].num    <= '0;
      side_q[0].id     <= '0;
      side_q[0].above  <= 1'b0;
      for (int l = 0; l < 4; l++) begin
        rem_q[0][l] <= (NW'(item_i.un[l]) << FRAC_BITS) + NW'(item_i.ud[l] >> 1);
        ud_q[0][l]  <= item_i.ud[l];
        quo_q[0][l] <= '0;
      end
    end
  end

  // divider steps, one quotient bit a stage; decider in the first two stages
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned K = QW - 1 - s;
    logic [NW:0]            trial [0:3];
    mscell_pkg::cell_side_t side_d;
    logic signed [34:0]     diff;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = {1'b0, rem_q[s][l]} - ((NW + 1)'(ud_q[s][l]) << K);
      end
      side_d = side_q[s];
      diff   = 35'(side_q[s].num) - 35'(side_q[s].id);
      if (s == 0) begin
        side_d.num = 33'(side_q[s].p1) - 33'(side_q[s].p2);
        side_d.id  = 34'(side_q[s].iso) * 34'(side_q[s].den);
      end
      if (s == 1) begin
        if (side_q[s].mode && side_q[s].den > 18'sd0) side_d.above = (diff >= 35'sd0);
        else if (side_q[s].mode && side_q[s].den < 18'sd0) side_d.above = (diff <= 35'sd0);
        else side_d.above = (side_q[s].sum >= $signed({side_q[s].iso, 2'b00}));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[s+1] <= 1'b0;
      else if (en) sv_q[s+1] <= sv_q[s];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s+1] <= side_d;
        for (int l = 0; l < 4; l++) begin
          ud_q[s+1][l]  <= ud_q[s][l];
          rem_q[s+1][l] <= trial[l][NW] ? rem_q[s][l] : trial[l][NW-1:0];
          quo_q[s+1][l] <= quo_q[s][l] | (QW'(!trial[l][NW]) << K);
        end
      end
    end
  end

  // form endpoints and segment order
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      fr[l] = (quo_q[QW][l] > (QW'(1) << FRAC_BITS)) ? (QW'(1) << FRAC_BITS) : quo_q[QW][l];
    end
    px_d[mscell_pkg::EDGE_BOTTOM] = make_coord({1'b0, side_q[QW].col}, fr[0]);
    py_d[mscell_pkg::EDGE_BOTTOM] = make_coord({1'b0, side_q[QW].row}, '0);
    px_d[mscell_pkg::EDGE_UP]     = make_coord({1'b0, side_q[QW].col}, fr[1]);
    py_d[mscell_pkg::EDGE_UP]     = make_coord({1'b0, side_q[QW].row} + 11'd1, '0);
    px_d[mscell_pkg::EDGE_LEFT]   = make_coord({1'b0, side_q[QW].col}, '0);
    py_d[mscell_pkg::EDGE_LEFT]   = make_coord({1'b0, side_q[QW].row}, fr[2]);
    px_d[mscell_pkg::EDGE_RIGHT]  = make_coord({1'b0, side_q[QW].col} + 11'd1, '0);
    py_d[mscell_pkg::EDGE_RIGHT]  = make_coord({1'b0, side_q[QW].row}, fr[3]);
    flip = side_q[QW].above != side_q[QW].up0;
    if (!side_q[QW].saddle) begin
      ord_d[0] = side_q[QW].e0;
      ord_d[1] = side_q[QW].e1;
      ord_d[2] = side_q[QW].e0;
      ord_d[3] = side_q[QW].e1;
    end else if (flip) begin
      ord_d[0] = mscell_pkg::EDGE_BOTTOM;
      ord_d[1] = mscell_pkg::EDGE_LEFT;
      ord_d[2] = mscell_pkg::EDGE_UP;
      ord_d[3] = mscell_pkg::EDGE_RIGHT;
    end else begin
      ord_d[0] = mscell_pkg::EDGE_BOTTOM;
      ord_d[1] = mscell_pkg::EDGE_RIGHT;
      ord_d[2] = mscell_pkg::EDGE_LEFT;
      ord_d[3] = mscell_pkg::EDGE_UP;
    end
  end

  // advance hold stage; step through segments
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= 1'b0;
      hseg_q <= 1'b0;
    end else if (en) begin
      hv_q   <= sv_q[QW];
      hseg_q <= 1'b0;
    end else if (out_ready_i) begin
      hseg_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      two_q <= side_q[QW].saddle;
      for (int l = 0; l < 4; l++) begin
        ord_q[l] <= ord_d[l];
        px_q[l]  <= px_d[l];
        py_q[l]  <= py_d[l];
      end
    end
  end

  assign out_valid_o             = hv_q;
  assign out_data_o.start_x      = px_q[ord_q[{hseg_q, 1'b0}]];
  assign out_data_o.start_y      = py_q[ord_q[{hseg_q, 1'b0}]];
  assign out_data_o.end_x        = px_q[ord_q[{hseg_q, 1'b1}]];
  assign out_data_o.end_y        = py_q[ord_q[{hseg_q, 1'b1}]];
  assign out_data_o.last_segment = last;

endmodule

[rtl/core/marching_squares_cell_top.sv]
`timescale 1ns / 1ps
// A cell passes the front register, queue, pipeline head, divider stages and hold stage.
// Throughput: one cell per cycle while out_ready_i is high; a saddle cell holds the single
// output register until both its segments are taken. Inactive cells give no segment.
// The edge divisions run in a FRAC_BITS + 1 stage pipeline, one quotient bit a stage.
// Reset clears the pipeline valids, the queue and the registers (iso 0, midpoint decider).
module marching_squares_cell_top #(
  parameter int unsigned GRID_DIM  = 1024,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mscell_pkg::cell_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mscell_pkg::seg_out_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic signed [15:0]     iso_q;
  logic                   mode_q;
  logic                   fi_valid, fi_ready, fo_valid, fo_ready;
  mscell_pkg::cell_item_t fi_item, fo_item;

  assign cfg_ready_o = 1'b1;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q  <= '0;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mscell_pkg::CFG_ISO_LEVEL:    iso_q  <= cfg_data_i;
        mscell_pkg::CFG_DECIDER_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mscell_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .iso_level_i    (iso_q),
    .decider_mode_i (mode_q),
    .item_valid_o   (fi_valid),
    .item_ready_i   (fi_ready),
    .item_o         (fi_item)
  );

  mscell_fifo #(
    .WIDTH ($bits(mscell_pkg::cell_item_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fi_valid),
    .ready_o (fi_ready),
    .data_i  (fi_item),
    .valid_o (fo_valid),
    .ready_i (fo_ready),
    .data_o  (fo_item)
  );

  mscell_back #(
    .GRID_DIM  (GRID_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fo_valid),
    .item_ready_o (fo_ready),
    .item_i       (fo_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
